### rtl/nfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared widths, operation and status codes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    localparam int WORD_W   = 32;
    localparam int WBIT_W   = 5;
    localparam int OP_W     = 2;
    localparam int SLOT_F_W = 8;
    localparam int TAG_W    = 24;
    localparam int ST_W     = 2;
    localparam int CNT_F_W  = 9;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_USED = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic free_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic miss;
    } t_dp_sts;

endpackage

### rtl/nfsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_if
// Request and result channels of the slot allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nfsa_in_if;
    logic                          valid;
    logic                          ready;
    logic [nfsa_pkg::OP_W-1:0]     operation;
    logic [nfsa_pkg::SLOT_F_W-1:0] slot_to_free;
    logic [nfsa_pkg::TAG_W-1:0]    line_tag;

    modport source (output valid, output operation, output slot_to_free,
                    output line_tag, input ready);
    modport sink (input valid, input operation, input slot_to_free,
                  input line_tag, output ready);
endinterface

interface nfsa_out_if;
    logic                          valid;
    logic                          ready;
    logic [nfsa_pkg::SLOT_F_W-1:0] granted_slot;
    logic [nfsa_pkg::ST_W-1:0]     status;
    logic [nfsa_pkg::CNT_F_W-1:0]  used_count;

    modport source (output valid, output granted_slot, output status,
                    output used_count, input ready);
    modport sink (input valid, input granted_slot, input status,
                  input used_count, output ready);
endinterface

### rtl/next_fit_slot_allocator.sv
`timescale 1ns / 1ps
// Sequence: a count goes from accept straight to the result register; a free
// reads and then writes the flag word of the victim slot; an allocate scans
// flag words from the search position until a free slot or a full pool is found.
// One request at a time: a new request is accepted only after the result of the
// last one is loaded. The flag memory scan is one 32-slot word per cycle. After
// reset the block clears the flag memory before it accepts the first request.
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Next-fit allocator over a pool of fixed slots with used counter.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator #(
    parameter int NUM_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfsa_in_if.sink     i_in,
    nfsa_out_if.source  o_out
);

    nfsa_pkg::t_dp_cmd cmd;
    nfsa_pkg::t_dp_sts sts;

    nfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.operation),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    nfsa_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_slot_to_free (i_in.slot_to_free),
        .i_line_tag     (i_in.line_tag),
        .o_sts          (sts),
        .o_granted_slot (o_out.granted_slot),
        .o_status       (o_out.status),
        .o_used_count   (o_out.used_count)
    );

endmodule

### rtl/nfsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Controller: sequences the clearing pass, the word scan of an allocate,
// the read-modify-write of a free and the hand-off to the result register.
// ----------------------------------------------------------------------------
module nfsa_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [nfsa_pkg::OP_W-1:0] i_op,
    input  logic                      i_out_ready,
    input  nfsa_pkg::t_dp_sts         i_sts,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output nfsa_pkg::t_dp_cmd         o_cmd
);

    nfsa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nfsa_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            nfsa_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = nfsa_pkg::S_IDLE;
                end
            end
            nfsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    case (i_op)
                        nfsa_pkg::OP_ALLOC: n_state = nfsa_pkg::S_SCAN;
                        nfsa_pkg::OP_FREE:  n_state = nfsa_pkg::S_FREE_RD;
                        default:            n_state = nfsa_pkg::S_FINISH;
                    endcase
                end
            end
            nfsa_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    n_state = nfsa_pkg::S_FINISH;
                end
            end
            nfsa_pkg::S_FREE_RD: begin
                n_state = nfsa_pkg::S_FREE_WR;
            end
            nfsa_pkg::S_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                n_state       = nfsa_pkg::S_FINISH;
            end
            nfsa_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = nfsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfsa_pkg::S_CLEAR;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/nfsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_dp
// Datapath: used flags packed into words of a memory, tag memory, search
// position, used counter, one-word-per-cycle rotating free-slot search and
// the result register.
// ----------------------------------------------------------------------------
module nfsa_dp #(
    parameter int NUM_SLOTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nfsa_pkg::t_dp_cmd             i_cmd,
    input  logic [nfsa_pkg::SLOT_F_W-1:0] i_slot_to_free,
    input  logic [nfsa_pkg::TAG_W-1:0]    i_line_tag,
    output nfsa_pkg::t_dp_sts             o_sts,
    output logic [nfsa_pkg::SLOT_F_W-1:0] o_granted_slot,
    output logic [nfsa_pkg::ST_W-1:0]     o_status,
    output logic [nfsa_pkg::CNT_F_W-1:0]  o_used_count
);

    localparam int WORD_W = nfsa_pkg::WORD_W;
    localparam int WBIT_W = nfsa_pkg::WBIT_W;
    localparam int NW     = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int NW_W   = (NW > 1) ? $clog2(NW) : 1;
    localparam int IDX_W  = NW_W + WBIT_W;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int VIS_W  = $clog2(NW + 2);
    localparam int CX_W   = (CNT_W > nfsa_pkg::CNT_F_W) ? CNT_W : nfsa_pkg::CNT_F_W;
    localparam int GX_W   = (IDX_W > nfsa_pkg::SLOT_F_W) ? IDX_W : nfsa_pkg::SLOT_F_W;

    logic [WORD_W-1:0]              r_flags [NW];
    logic [nfsa_pkg::TAG_W-1:0]     r_tags  [NUM_SLOTS];
    logic [WORD_W-1:0]              r_rdata;
    logic [IDX_W-1:0]               r_pos;
    logic [CNT_W-1:0]               r_count;
    logic [NW_W-1:0]                r_clr_addr;
    logic                           r_chk_v;
    logic [NW_W-1:0]                r_raddr;
    logic [VIS_W-1:0]               r_iss;
    logic [NW_W-1:0]                r_chk_word;
    logic [VIS_W-1:0]               r_chk_vis;
    logic [nfsa_pkg::SLOT_F_W-1:0]  r_victim;
    logic [nfsa_pkg::TAG_W-1:0]     r_tag;
    logic [IDX_W-1:0]               r_res_slot;
    logic [nfsa_pkg::ST_W-1:0]      r_res_st;
    logic [nfsa_pkg::SLOT_F_W-1:0]  r_out_slot;
    logic [nfsa_pkg::ST_W-1:0]      r_out_st;
    logic [nfsa_pkg::CNT_F_W-1:0]   r_out_cnt;

    logic [NW_W-1:0]   pos_word;
    logic [WBIT_W-1:0] pos_bit;
    logic [GX_W-1:0]   vx;
    logic [IDX_W-1:0]  vidx;
    logic [NW_W-1:0]   vword;
    logic [WBIT_W-1:0] vbit;
    logic              v_in_range;
    logic              vused;
    logic [NW_W-1:0]   rd_addr;
    logic              iss_en;
    logic [WORD_W-1:0] avail;
    logic              found;
    logic [WBIT_W-1:0] fbit;
    logic [IDX_W-1:0]  hidx;
    logic [IDX_W-1:0]  npos;
    logic              hit;
    logic              miss;
    logic [CX_W-1:0]   cx;
    logic [GX_W-1:0]   gx;

    assign pos_word   = r_pos[IDX_W-1:WBIT_W];
    assign pos_bit    = r_pos[WBIT_W-1:0];
    assign vx         = GX_W'(r_victim);
    assign vidx       = vx[IDX_W-1:0];
    assign vword      = vidx[IDX_W-1:WBIT_W];
    assign vbit       = vidx[WBIT_W-1:0];
    assign v_in_range = 32'(r_victim) < NUM_SLOTS;
    assign vused      = r_rdata[vbit];
    assign rd_addr    = i_cmd.scan ? r_raddr : vword;
    assign iss_en     = r_iss <= VIS_W'(NW);

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            avail[b] = (32'({r_chk_word, WBIT_W'(b)}) < NUM_SLOTS)
                     && ((r_chk_vis != '0) || (WBIT_W'(b) >= pos_bit))
                     && ((r_chk_vis != VIS_W'(NW)) || (WBIT_W'(b) < pos_bit))
                     && !r_rdata[b];
        end
    end

    always_comb begin
        fbit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (avail[b]) begin
                fbit = WBIT_W'(b);
            end
        end
    end

    assign found = |avail;
    assign hidx  = {r_chk_word, fbit};
    assign npos  = (32'(hidx) == NUM_SLOTS - 1) ? '0 : hidx;
    assign hit   = i_cmd.scan && r_chk_v && found;
    assign miss  = i_cmd.scan && r_chk_v && !found && (r_chk_vis == VIS_W'(NW));

    assign o_sts.clr_last = r_clr_addr == NW_W'(NW - 1);
    assign o_sts.hit      = hit;
    assign o_sts.miss     = miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_count    <= '0;
            r_clr_addr <= '0;
            r_chk_v    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + NW_W'(1);
            end
            if (i_cmd.start) begin
                r_chk_v <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_v <= iss_en;
            end
            if (hit) begin
                r_pos   <= npos;
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.free_wr && v_in_range && vused) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_victim   <= i_slot_to_free;
            r_tag      <= i_line_tag;
            r_raddr    <= pos_word;
            r_iss      <= '0;
            r_res_slot <= '0;
            r_res_st   <= nfsa_pkg::ST_OK;
        end
        if (i_cmd.scan) begin
            if (iss_en) begin
                r_raddr    <= (r_raddr == NW_W'(NW - 1)) ? '0 : r_raddr + NW_W'(1);
                r_iss      <= r_iss + VIS_W'(1);
                r_chk_word <= r_raddr;
                r_chk_vis  <= r_iss;
            end
            if (hit) begin
                r_res_slot <= hidx;
            end
            if (miss) begin
                r_res_st <= nfsa_pkg::ST_FULL;
            end
        end
        if (i_cmd.free_wr && (!v_in_range || !vused)) begin
            r_res_st <= nfsa_pkg::ST_NOT_USED;
        end
        if (i_cmd.load_out) begin
            r_out_slot <= gx[nfsa_pkg::SLOT_F_W-1:0];
            r_out_st   <= r_res_st;
            r_out_cnt  <= cx[nfsa_pkg::CNT_F_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_flags[rd_addr];
        if (i_cmd.clear) begin
            r_flags[r_clr_addr] <= '0;
        end else if (hit) begin
            r_flags[r_chk_word] <= r_rdata | (WORD_W'(1) << fbit);
        end else if (i_cmd.free_wr && v_in_range && vused) begin
            r_flags[vword] <= r_rdata & ~(WORD_W'(1) << vbit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_tags[hidx[SLOT_W-1:0]] <= r_tag;
        end else if (i_cmd.free_wr && v_in_range) begin
            r_tags[vidx[SLOT_W-1:0]] <= '0;
        end
    end

    assign cx             = CX_W'(r_count);
    assign gx             = GX_W'(r_res_slot);
    assign o_granted_slot = r_out_slot;
    assign o_status       = r_out_st;
    assign o_used_count   = r_out_cnt;

endmodule

### rtl/nfsa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_chk
// Port-level checks on the result channel of the slot allocator.
// ----------------------------------------------------------------------------
module nfsa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [nfsa_pkg::SLOT_F_W-1:0] i_granted_slot,
    input logic [nfsa_pkg::ST_W-1:0]     i_status,
    input logic [nfsa_pkg::CNT_F_W-1:0]  i_used_count
);

    logic [nfsa_pkg::CNT_F_W-1:0] r_last_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_cnt <= i_used_count;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_granted_slot)
            && $stable(i_status) && $stable(i_used_count))
        else $error("result word changed while stalled");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == nfsa_pkg::ST_FULL) |-> i_granted_slot == '0)
        else $error("full pool reported with a nonzero slot");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_used_count == r_last_cnt)
            || (i_used_count == r_last_cnt + 9'd1)
            || (i_used_count + 9'd1 == r_last_cnt))
        else $error("used count moved by more than one");

    a_err_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != nfsa_pkg::ST_OK) |-> i_used_count == r_last_cnt)
        else $error("failed request changed the used count");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind next_fit_slot_allocator nfsa_chk u_nfsa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_granted_slot (o_out.granted_slot),
    .i_status       (o_out.status),
    .i_used_count   (o_out.used_count)
);
